@@ rtl/bbt_pkg.sv @@
package bbt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = 8;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [2:0] MODE_GET        = 3'd0;
  localparam logic [2:0] MODE_RELEASE    = 3'd1;
  localparam logic [2:0] MODE_PIN        = 3'd2;
  localparam logic [2:0] MODE_UNPIN      = 3'd3;
  localparam logic [2:0] MODE_MARK_VALID = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  // controller to datapath commands, one step each
  typedef struct packed {
    logic load;
    logic compare;
    logic pick;
    logic update;
  } bbt_cmd_t;

endpackage

@@ rtl/bbt_ctrl.sv @@
module bbt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output bbt_pkg::bbt_cmd_t cmd_o
);
  import bbt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start) state_d = S_CMP;
      S_CMP:  state_d = S_PICK;
      S_PICK: state_d = S_UPD;
      S_UPD:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy          = (state_q != S_IDLE);
  assign cmd_o.load    = (state_q == S_IDLE) && start;
  assign cmd_o.compare = (state_q == S_CMP);
  assign cmd_o.pick    = (state_q == S_PICK);
  assign cmd_o.update  = (state_q == S_UPD);
  assign done_o        = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.update;
    end
  end

endmodule

@@ rtl/bbt_dp.sv @@
module bbt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbt_pkg::bbt_cmd_t cmd_i,
  input  logic [2:0]        mode_i,
  input  logic [15:0]       device_i,
  input  logic [31:0]       block_number_i,
  input  logic [4:0]        entry_index_i,
  output logic [4:0]        granted_index_o,
  output logic              was_hit_o,
  output logic              contents_valid_o,
  output logic [1:0]        status_o
);
  import bbt_pkg::*;

  // table
  logic [15:0]      tag_dev_q [ENTRIES];
  logic [31:0]      tag_blk_q [ENTRIES];
  logic [ENTRIES-1:0] tagged_q, tagged_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] cnt_q [ENTRIES];
  logic [CNT_W-1:0] cnt_d [ENTRIES];
  logic             retag;

  // request
  logic [2:0]  mode_q;
  logic [15:0] dev_q;
  logic [31:0] blk_q;
  logic [4:0]  eidx_q;

  // compare step
  logic [ENTRIES-1:0] match_q, free_q;

  // pick step
  logic [IDX_W-1:0] tgt_q, tgt_d;
  logic             hit_q, nofree_q, inrange_q;
  logic [IDX_W-1:0] hit_idx, free_idx;

  // update step
  logic [4:0]       gidx_q, gidx_d;
  logic             whit_q, whit_d, cvld_q, cvld_d;
  logic [1:0]       st_q, st_d;
  logic [CNT_W-1:0] cnt_rd;
  logic             vld_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      dev_q  <= device_i;
      blk_q  <= block_number_i;
      eidx_q <= entry_index_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match_q[i] <= tagged_q[i] && (tag_dev_q[i] == dev_q) && (tag_blk_q[i] == blk_q);
        free_q[i]  <= (cnt_q[i] == '0);
      end
    end
  end

  // lowest index wins
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx  = IDX_W'(i);
      if (free_q[i])  free_idx = IDX_W'(i);
    end
  end

  always_comb begin
    if (mode_q != MODE_GET)  tgt_d = IDX_W'(eidx_q);
    else if (|match_q)       tgt_d = hit_idx;
    else                     tgt_d = free_idx;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      tgt_q     <= tgt_d;
      hit_q     <= |match_q;
      nofree_q  <= !(|match_q) && !(|free_q);
      inrange_q <= (32'(eidx_q) < ENTRIES);
    end
  end

  assign cnt_rd = cnt_q[tgt_q];
  assign vld_rd = valid_q[tgt_q];

  always_comb begin
    cnt_d    = cnt_q;
    tagged_d = tagged_q;
    valid_d  = valid_q;
    retag    = 1'b0;
    gidx_d   = eidx_q;
    whit_d   = 1'b0;
    cvld_d   = vld_rd;
    st_d     = ST_OK;
    if (mode_q == MODE_GET) begin
      gidx_d = 5'(tgt_q);
      if (nofree_q) begin
        gidx_d = '0;
        cvld_d = 1'b0;
        st_d   = ST_NO_FREE;
      end else if (hit_q) begin
        whit_d = 1'b1;
        if (cnt_rd == COUNT_MAX) st_d = ST_SATURATED;
        else cnt_d[tgt_q] = cnt_rd + 1'b1;
      end else begin
        retag           = 1'b1;
        tagged_d[tgt_q] = 1'b1;
        valid_d[tgt_q]  = 1'b0;
        cnt_d[tgt_q]    = CNT_W'(1);
        cvld_d          = 1'b0;
      end
    end else if (!inrange_q) begin
      cvld_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_RELEASE, MODE_UNPIN: begin
          if (cnt_rd == '0) st_d = ST_UNDERFLOW;
          else cnt_d[tgt_q] = cnt_rd - 1'b1;
        end
        MODE_PIN: begin
          if (cnt_rd == COUNT_MAX) st_d = ST_SATURATED;
          else cnt_d[tgt_q] = cnt_rd + 1'b1;
        end
        MODE_MARK_VALID: begin
          valid_d[tgt_q] = 1'b1;
          cvld_d         = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tagged_q <= '0;
      valid_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) cnt_q[i] <= '0;
    end else if (cmd_i.update) begin
      tagged_q <= tagged_d;
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
    end
  end

  // tags only count once tagged, so no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && retag) begin
      tag_dev_q[tgt_q] <= dev_q;
      tag_blk_q[tgt_q] <= blk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      gidx_q <= gidx_d;
      whit_q <= whit_d;
      cvld_q <= cvld_d;
      st_q   <= st_d;
    end
  end

  assign granted_index_o  = gidx_q;
  assign was_hit_o        = whit_q;
  assign contents_valid_o = cvld_q;
  assign status_o         = st_q;

endmodule

@@ rtl/block_buffer_tag_table.sv @@
// Buffer tag table with reference counts. A request is taken on a clock
// edge where start is high and busy is low; its result appears on the
// result ports for exactly one cycle with done_o high, after the compare,
// pick and update steps. The receiver cannot stall, so sample the result in
// that cycle. A new request may be issued in the cycle the result shows;
// busy refuses one before that. The controller steps through compare /
// pick / update (all 32 tags compared in the compare step, the lowest
// matching or free entry picked in the pick step, the entry counted in the
// update step).
// Get: hit bumps the count unless saturated; miss claims the lowest entry with count zero.
// Release/unpin decrement, pin increments, mark-valid sets the valid mark.
module block_buffer_tag_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [15:0] device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  entry_index_i,
  output logic        done_o,
  output logic [4:0]  granted_index_o,
  output logic        was_hit_o,
  output logic        contents_valid_o,
  output logic [1:0]  status_o
);
  import bbt_pkg::*;

  bbt_cmd_t cmd;

  // sequencer: idle -> compare -> pick -> update
  bbt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // tag table, counts and result registers
  bbt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .mode_i           (mode_i),
    .device_i         (device_i),
    .block_number_i   (block_number_i),
    .entry_index_i    (entry_index_i),
    .granted_index_o  (granted_index_o),
    .was_hit_o        (was_hit_o),
    .contents_valid_o (contents_valid_o),
    .status_o         (status_o)
  );

endmodule

@@ rtl/bbt_check.sv @@
module bbt_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [4:0] granted_index_o,
  input logic       was_hit_o,
  input logic       contents_valid_o,
  input logic [1:0] status_o
);
  import bbt_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in flight");

  a_nofree_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_NO_FREE) |->
      (granted_index_o == '0 && !was_hit_o && !contents_valid_o))
    else $error("no-free result fields not cleared");

  a_hit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && was_hit_o) |-> (status_o == ST_OK || status_o == ST_SATURATED))
    else $error("hit reported with bad status");

endmodule

bind block_buffer_tag_table bbt_check u_bbt_check (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .granted_index_o  (granted_index_o),
  .was_hit_o        (was_hit_o),
  .contents_valid_o (contents_valid_o),
  .status_o         (status_o)
);

@@ test/bbt_tag_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and result channels of the tag table, keeps a shadow
// copy of the table and checks every result against it in order.
module bbt_tag_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  mode_i,
  input  logic [15:0] device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  entry_index_i,
  input  logic        done_i,
  input  logic [4:0]  granted_index_i,
  input  logic        was_hit_i,
  input  logic        contents_valid_i,
  input  logic [1:0]  status_i,
  output int          fail_count_o,
  output int          pending_o
);
  import bbt_pkg::*;

  typedef struct packed {
    logic [4:0] index;
    logic       hit;
    logic       valid;
    logic [1:0] status;
  } grant_t;

  logic [15:0]      dev_tag   [ENTRIES];
  logic [31:0]      blk_tag   [ENTRIES];
  logic             is_tagged [ENTRIES];
  logic             is_valid  [ENTRIES];
  logic [CNT_W-1:0] ref_cnt   [ENTRIES];

  grant_t grants_due[$];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Applies one request to the shadow table and returns the grant it yields.
  task automatic apply_table_request(input logic [2:0] mode, input logic [15:0] dev,
                                     input logic [31:0] blk, input logic [4:0] idx,
                                     output grant_t res);
    int hit_at;
    int free_at;
    hit_at  = -1;
    free_at = -1;
    res     = '0;
    if (mode == MODE_GET) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_at < 0 && is_tagged[i] && dev_tag[i] == dev && blk_tag[i] == blk)
          hit_at = i;
      end
      if (hit_at >= 0) begin
        res.index = hit_at[4:0];
        res.hit   = 1'b1;
        res.valid = is_valid[hit_at];
        if (ref_cnt[hit_at] == COUNT_MAX) res.status = ST_SATURATED;
        else ref_cnt[hit_at] = ref_cnt[hit_at] + 1'b1;
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_at < 0 && ref_cnt[i] == '0) free_at = i;
        end
        if (free_at >= 0) begin
          // claim: retag, drop valid, count one
          dev_tag[free_at]   = dev;
          blk_tag[free_at]   = blk;
          is_tagged[free_at] = 1'b1;
          is_valid[free_at]  = 1'b0;
          ref_cnt[free_at]   = CNT_W'(1);
          res.index          = free_at[4:0];
        end else begin
          res.status = ST_NO_FREE;
        end
      end
    end else begin
      res.index = idx;
      if (int'(idx) < ENTRIES) begin
        case (mode)
          MODE_RELEASE, MODE_UNPIN: begin
            if (ref_cnt[idx] == '0) res.status = ST_UNDERFLOW;
            else ref_cnt[idx] = ref_cnt[idx] - 1'b1;
          end
          MODE_PIN: begin
            if (ref_cnt[idx] == COUNT_MAX) res.status = ST_SATURATED;
            else ref_cnt[idx] = ref_cnt[idx] + 1'b1;
          end
          MODE_MARK_VALID: is_valid[idx] = 1'b1;
          default: ;
        endcase
        res.valid = is_valid[idx];
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    grant_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        dev_tag[i]   = '0;
        blk_tag[i]   = '0;
        is_tagged[i] = 1'b0;
        is_valid[i]  = 1'b0;
        ref_cnt[i]   = '0;
      end
      grants_due.delete();
    end else begin
      if (done_i === 1'b1) begin
        if (grants_due.size() == 0) begin
          flag_mismatch("result with no request outstanding", 32'd1, 32'd0);
        end else begin
          want = grants_due.pop_front();
          if (granted_index_i !== want.index)
            flag_mismatch("granted_index", 32'(granted_index_i), 32'(want.index));
          if (was_hit_i !== want.hit)
            flag_mismatch("was_hit", 32'(was_hit_i), 32'(want.hit));
          if (contents_valid_i !== want.valid)
            flag_mismatch("contents_valid", 32'(contents_valid_i), 32'(want.valid));
          if (status_i !== want.status)
            flag_mismatch("status", 32'(status_i), 32'(want.status));
        end
      end
      if (start_i && !busy_i) begin
        apply_table_request(mode_i, device_i, block_number_i, entry_index_i, fresh);
        grants_due.push_back(fresh);
      end
    end
    pending_o = grants_due.size();
  end

endmodule

@@ test/tb_block_buffer_tag_table.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the buffer tag table. Checking lives in
// bbt_tag_checker; this module only drives requests and waits.
module tb_block_buffer_tag_table;
  import bbt_pkg::*;

  // modes 5..7 have no meaning and must leave the table alone
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  localparam int RANDOM_PER_PHASE = 35;
  // a result shows after the compare, pick and update steps; 72% sender idling
  // makes long gaps possible, but never near this many quiet cycles
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int TAIL_CYCLES      = 8;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [2:0]  mode           = MODE_GET;
  logic [15:0] device         = '0;
  logic [31:0] block_number   = '0;
  logic [4:0]  entry_index    = '0;
  logic        done;
  logic [4:0]  granted_index;
  logic        was_hit;
  logic        contents_valid;
  logic [1:0]  status;

  int          fail_count;
  int          pending;
  int          sender_idle_pct = 0;
  int          quiet_cycles    = 0;
  logic [4:0]  last_grant      = '0;

  // tag pool for the random mix, so gets hit as well as miss
  logic [15:0] pool_dev [8];
  logic [31:0] pool_blk [8];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  block_buffer_tag_table u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode),
    .device_i         (device),
    .block_number_i   (block_number),
    .entry_index_i    (entry_index),
    .done_o           (done),
    .granted_index_o  (granted_index),
    .was_hit_o        (was_hit),
    .contents_valid_o (contents_valid),
    .status_o         (status)
  );

  bbt_tag_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .mode_i           (mode),
    .device_i         (device),
    .block_number_i   (block_number),
    .entry_index_i    (entry_index),
    .done_i           (done),
    .granted_index_i  (granted_index),
    .was_hit_i        (was_hit),
    .contents_valid_i (contents_valid),
    .status_i         (status),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // remember the last granted entry so a burst of gets can be undone
  always @(posedge clk_i) begin
    if (done) last_grant <= granted_index;
  end

  // any transfer on either channel counts as progress
  always @(posedge clk_i) begin
    if ((start && !busy) || done) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("block_buffer_tag_table regression: fail");
      $finish;
    end
  end

  // One request transfer. start stays high across back-to-back requests;
  // it only drops for idle cycles, so it never gets two updates in a step.
  task automatic send(input logic [2:0] m, input logic [15:0] dev,
                      input logic [31:0] blk, input logic [4:0] idx);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    mode         <= m;
    device       <= dev;
    block_number <= blk;
    entry_index  <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold off until every result owed has come back. The extra edge lets the
  // checker book the last transfer before its count is read.
  task automatic wait_results_in();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly pool gets and releases on low entries (where gets land), with
  // full-range tags and indexes, pins, mark-valid and spare modes mixed in.
  task automatic random_mix(input int count);
    int pick;
    int slot;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      slot = $urandom_range(7);
      if (pick < 45)
        send(MODE_GET, pool_dev[slot], pool_blk[slot], 5'($urandom));
      else if (pick < 80)
        send(($urandom_range(1)) ? MODE_RELEASE : MODE_UNPIN, 16'($urandom), $urandom,
             ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(11)));
      else if (pick < 85)
        send(MODE_PIN, 16'($urandom), $urandom, 5'($urandom));
      else if (pick < 93)
        send(MODE_MARK_VALID, 16'($urandom), $urandom,
             ($urandom_range(1)) ? 5'($urandom) : 5'($urandom_range(11)));
      else if (pick < 97)
        send(MODE_GET, 16'($urandom), $urandom, 5'($urandom));
      else
        send(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)), 16'($urandom),
             $urandom, 5'($urandom));
    end
  endtask

  initial begin
    int          idle_by_phase [4];
    logic [15:0] hot_dev;
    logic [31:0] hot_blk;
    idle_by_phase = '{0, 72, 0, 33};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: miss into entry 0 with all-zero tag, all-ones tag next
    send(MODE_GET, 16'h0000, 32'h0000_0000, 5'd0);
    send(MODE_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
    send(MODE_GET, 16'h0000, 32'h0000_0000, 5'd0);  // hit, not yet valid
    send(MODE_MARK_VALID, 16'h0, 32'h0, 5'd0);
    send(MODE_GET, 16'h0000, 32'h0000_0000, 5'd0);  // hit, valid
    send(MODE_RELEASE, 16'h0, 32'h0, 5'd0);
    send(MODE_UNPIN, 16'h0, 32'h0, 5'd0);
    send(MODE_RELEASE, 16'h0, 32'h0, 5'd0);
    send(MODE_UNPIN, 16'h0, 32'h0, 5'd0);           // underflow
    send(MODE_RELEASE, 16'h0, 32'h0, 5'd31);        // underflow on top entry
    send(MODE_PIN, 16'h0, 32'h0, 5'd31);
    send(MODE_MARK_VALID, 16'h0, 32'h0, 5'd31);     // untagged entry
    send(MODE_SPARE_FIRST, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
    send(MODE_SPARE_MID, 16'h0, 32'h0, 5'd0);
    send(MODE_SPARE_LAST, 16'h0, 32'h0, 5'd2);
    send(MODE_GET, 16'h0000, 32'h0000_0000, 5'd0);  // tagged but free: still a hit
    send(MODE_GET, 16'h1234, 32'h0000_0005, 5'd0);  // miss, lowest free entry
    send(MODE_MARK_VALID, 16'h0, 32'h0, 5'd2);
    send(MODE_GET, 16'h1234, 32'h0000_0005, 5'd0);
    send(MODE_RELEASE, 16'h0, 32'h0, 5'd0);
    send(MODE_GET, 16'hA5A5, 32'h5A5A_A5A5, 5'd0);  // retags entry 0, drops valid

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_by_phase[phase];
      pool_dev[0] = 16'h0000;
      pool_blk[0] = 32'h0000_0000;
      pool_dev[1] = 16'hFFFF;
      pool_blk[1] = 32'hFFFF_FFFF;
      for (int s = 2; s < 8; s++) begin
        pool_dev[s] = 16'($urandom);
        pool_blk[s] = $urandom;
      end

      case (phase)
        0: begin
          // get hits until the count saturates, pin the saturated entry,
          // then release it all back and past zero
          hot_dev = 16'($urandom);
          hot_blk = $urandom;
          repeat (257) send(MODE_GET, hot_dev, hot_blk, 5'($urandom));
          wait_results_in();
          repeat (2) send(MODE_PIN, 16'($urandom), $urandom, last_grant);
          repeat (257) send(MODE_RELEASE, 16'($urandom), $urandom, last_grant);
        end
        2: begin
          // fill the table with fresh tags until gets find no free entry
          repeat (34) send(MODE_GET, 16'($urandom), $urandom, 5'($urandom));
          for (int pass = 0; pass < 3; pass++) begin
            for (int e = 0; e < ENTRIES; e++)
              send(MODE_RELEASE, 16'($urandom), $urandom, e[4:0]);
          end
        end
        default: ;
      endcase

      random_mix(RANDOM_PER_PHASE);
      wait_results_in();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("block_buffer_tag_table regression: pass");
    end else begin
      $display("block_buffer_tag_table regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bbt_pkg.sv
rtl/bbt_ctrl.sv
rtl/bbt_dp.sv
rtl/block_buffer_tag_table.sv
rtl/bbt_check.sv
test/bbt_tag_checker.sv
test/tb_block_buffer_tag_table.sv
